// ----- design/bright_region_labeler_assert.svh -----
// ----------------------------------------------------------------------------
// bright_region_labeler assertion macros
// Concurrent assertion shorthands that are compiled away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BRIGHT_REGION_LABELER_ASSERT_SVH
`define BRIGHT_REGION_LABELER_ASSERT_SVH
`ifndef SYNTH
`define BRL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BRL_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define BRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/brl_pkg.sv -----
// ----------------------------------------------------------------------------
// brl_pkg
// Shared constants of the bright region labeler.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_PIXEL_BITS = 16;

    localparam logic [7:0] DIM_MARK    = 8'd0;
    localparam logic [7:0] BRIGHT_MARK = 8'd1;
    localparam logic [7:0] FIRST_LABEL = 8'd2;
    localparam logic [7:0] LAST_LABEL  = 8'd254;
    localparam logic [7:0] SEED_MARK   = 8'd255;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_RUN  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    localparam logic ANS_RUN  = 1'b0;
    localparam logic ANS_READ = 1'b1;

    typedef logic [7:0] label_t;

endpackage

// ----- design/brl_if.sv -----
// ----------------------------------------------------------------------------
// brl_in_if / brl_out_if
// Valid/ready channels for command transactions and answer transactions.
// ----------------------------------------------------------------------------
interface brl_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [15:0] pixel_value;

    modport source (output valid, output kind, output col, output row,
                    output pixel_value, input ready);
    modport sink (input valid, input kind, input col, input row,
                  input pixel_value, output ready);
endinterface

interface brl_out_if;
    logic       valid;
    logic       ready;
    logic       answer_kind;
    logic [7:0] pixel_label;
    logic [7:0] component_count;
    logic       too_many;

    modport source (output valid, output answer_kind, output pixel_label,
                    output component_count, output too_many, input ready);
    modport sink (input valid, input answer_kind, input pixel_label,
                  input component_count, input too_many, output ready);
endinterface

// ----- design/bright_region_labeler.sv -----
// ----------------------------------------------------------------------------
// bright_region_labeler
// Labels the seeded four-connected bright regions of a stored image.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// in_ch     sink       load pixel, run labeling or read label
// out_ch    source     run answer or label read answer
// cfg       write      image_width, image_height, bright_limit
//
// A load writes the pixel store on acceptance; a read answer is registered
// through the S_READ state. A run makes a threshold pass over the window
// (after a maximum pass when the limit is zero), then a seed scan and a fill
// of each seeded region, paced by the single-port stores.
// Reset clears control state only; the stores hold nothing defined until written.
// A stalled answer blocks new transactions until it is taken.
module bright_region_labeler #(
    parameter int MAX_WIDTH  = brl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = brl_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = brl_pkg::DEF_PIXEL_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    brl_in_if.sink      in_ch,
    brl_out_if.source   out_ch
);
    import brl_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int AW = XW + YW;

    logic                  pix_we, lab_we, stk_we;
    logic [AW-1:0]         pix_addr, lab_addr, stk_addr, stk_wdata, stk_rdata;
    logic [PIXEL_BITS-1:0] pix_wdata, pix_rdata;
    label_t                lab_wdata, lab_rdata;

    brl_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS),
        .XW         (XW),
        .YW         (YW),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .pix_we    (pix_we),
        .pix_addr  (pix_addr),
        .pix_wdata (pix_wdata),
        .pix_rdata (pix_rdata),
        .lab_we    (lab_we),
        .lab_addr  (lab_addr),
        .lab_wdata (lab_wdata),
        .lab_rdata (lab_rdata),
        .stk_we    (stk_we),
        .stk_addr  (stk_addr),
        .stk_wdata (stk_wdata),
        .stk_rdata (stk_rdata)
    );

    brl_ram #(.DATA_BITS(PIXEL_BITS), .ADDR_BITS(AW)) u_pixel_store (
        .clk   (clk),
        .we    (pix_we),
        .addr  (pix_addr),
        .wdata (pix_wdata),
        .rdata (pix_rdata)
    );

    brl_ram #(.DATA_BITS(8), .ADDR_BITS(AW)) u_label_store (
        .clk   (clk),
        .we    (lab_we),
        .addr  (lab_addr),
        .wdata (lab_wdata),
        .rdata (lab_rdata)
    );

    brl_ram #(.DATA_BITS(AW), .ADDR_BITS(AW)) u_fill_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );
endmodule

// ----- design/brl_ram.sv -----
// ----------------------------------------------------------------------------
// brl_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module brl_ram #(
    parameter int DATA_BITS = 8,
    parameter int ADDR_BITS = 12
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);
    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/brl_ctrl.sv -----
// ----------------------------------------------------------------------------
// brl_ctrl
// Command sequencer: loads, reads, maximum scan, threshold scan, seed scan and stack fill.
// ----------------------------------------------------------------------------
`include "bright_region_labeler_assert.svh"

module brl_ctrl #(
    parameter int MAX_WIDTH  = brl_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = brl_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = brl_pkg::DEF_PIXEL_BITS,
    parameter int XW         = $clog2(MAX_WIDTH),
    parameter int YW         = $clog2(MAX_HEIGHT),
    parameter int AW         = XW + YW
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    brl_in_if.sink                in_ch,
    brl_out_if.source             out_ch,
    output logic                  pix_we,
    output logic [AW-1:0]         pix_addr,
    output logic [PIXEL_BITS-1:0] pix_wdata,
    input  logic [PIXEL_BITS-1:0] pix_rdata,
    output logic                  lab_we,
    output logic [AW-1:0]         lab_addr,
    output brl_pkg::label_t       lab_wdata,
    input  brl_pkg::label_t       lab_rdata,
    output logic                  stk_we,
    output logic [AW-1:0]         stk_addr,
    output logic [AW-1:0]         stk_wdata,
    input  logic [AW-1:0]         stk_rdata
);
    import brl_pkg::*;

    localparam int PB = PIXEL_BITS;
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_READ     = 4'd1;
    localparam logic [3:0] S_MAX_RD   = 4'd2;
    localparam logic [3:0] S_MAX_CHK  = 4'd3;
    localparam logic [3:0] S_CLS_RD   = 4'd4;
    localparam logic [3:0] S_CLS_WR   = 4'd5;
    localparam logic [3:0] S_SEED_RD  = 4'd6;
    localparam logic [3:0] S_SEED_CHK = 4'd7;
    localparam logic [3:0] S_POP      = 4'd8;
    localparam logic [3:0] S_POP_DATA = 4'd9;
    localparam logic [3:0] S_NB_SEL   = 4'd10;
    localparam logic [3:0] S_NB_CHK   = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [XW:0]   w_reg, w_next;
    logic [YW:0]   h_reg, h_next;
    logic [PB-1:0] limit_reg, limit_next;
    logic [PB:0]   maximum_reg, maximum_next;
    label_t        lab_reg, lab_next;
    logic          too_reg, too_next;
    logic [AW:0]   top_reg, top_next;
    logic [AW-1:0] p_reg, p_next;
    logic [1:0]    k_reg, k_next;
    logic          inside_reg, inside_next;
    logic [6:0]    width_cfg_reg, height_cfg_reg;
    logic [15:0]   limit_cfg_reg;
    logic          out_valid_reg, out_valid_next;
    logic          out_kind_reg, out_kind_next;
    label_t        out_label_reg, out_label_next;
    logic [7:0]    out_count_reg, out_count_next;
    logic          out_too_reg, out_too_next;

    logic          accept;
    logic          x_last, y_last, scan_last;
    logic          in_inside;
    logic [10:0]   wc, hc;
    logic [PB-1:0] lim_in;
    logic [PB:0]   mx;
    logic [XW-1:0] p_x, nb_x;
    logic [YW-1:0] p_y, nb_y;
    logic          nb_ok;

    assign in_ch.ready          = (state_reg == S_IDLE) && (!out_valid_reg || out_ch.ready);
    assign accept               = in_ch.valid && in_ch.ready;
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.answer_kind   = out_kind_reg;
    assign out_ch.pixel_label   = out_label_reg;
    assign out_ch.component_count = out_count_reg;
    assign out_ch.too_many      = out_too_reg;

    assign x_last    = ({1'b0, x_reg} + (XW+1)'(1)) == w_reg;
    assign y_last    = ({1'b0, y_reg} + (YW+1)'(1)) == h_reg;
    assign scan_last = x_last && y_last;
    assign in_inside = (11'(in_ch.col) < 11'(MAX_WIDTH)) && (11'(in_ch.row) < 11'(MAX_HEIGHT));
    assign wc        = (11'(width_cfg_reg) > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH)
                                                            : 11'(width_cfg_reg);
    assign hc        = (11'(height_cfg_reg) > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT)
                                                              : 11'(height_cfg_reg);
    assign lim_in    = PB'(limit_cfg_reg);
    assign mx        = ({1'b0, pix_rdata} > maximum_reg) ? {1'b0, pix_rdata} : maximum_reg;
    assign p_x       = p_reg[XW-1:0];
    assign p_y       = p_reg[AW-1:XW];

    always_comb
    begin
        nb_x  = p_x;
        nb_y  = p_y;
        nb_ok = 1'b0;
        case (k_reg)
            2'd0:
            begin
                nb_ok = p_x != '0;
                nb_x  = p_x - XW'(1);
            end
            2'd1:
            begin
                nb_ok = p_y != '0;
                nb_y  = p_y - YW'(1);
            end
            2'd2:
            begin
                nb_ok = ({1'b0, p_x} + (XW+1)'(1)) < w_reg;
                nb_x  = p_x + XW'(1);
            end
            default:
            begin
                nb_ok = ({1'b0, p_y} + (YW+1)'(1)) < h_reg;
                nb_y  = p_y + YW'(1);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        limit_next     = limit_reg;
        maximum_next   = maximum_reg;
        lab_next       = lab_reg;
        too_next       = too_reg;
        top_next       = top_reg;
        p_next         = p_reg;
        k_next         = k_reg;
        inside_next    = inside_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_kind_next  = out_kind_reg;
        out_label_next = out_label_reg;
        out_count_next = out_count_reg;
        out_too_next   = out_too_reg;
        pix_we         = 1'b0;
        pix_addr       = {y_reg, x_reg};
        pix_wdata      = PB'(in_ch.pixel_value);
        lab_we         = 1'b0;
        lab_addr       = {y_reg, x_reg};
        lab_wdata      = lab_reg;
        stk_we         = 1'b0;
        stk_addr       = top_reg[AW-1:0];
        stk_wdata      = {nb_y, nb_x};

        case (state_reg)
            S_IDLE:
            begin
                pix_addr = {YW'(in_ch.row), XW'(in_ch.col)};
                lab_addr = {YW'(in_ch.row), XW'(in_ch.col)};
                if (accept)
                begin
                    case (in_ch.kind)
                        KIND_LOAD:
                        begin
                            pix_we = in_inside;
                        end
                        KIND_READ:
                        begin
                            inside_next = in_inside;
                            state_next  = S_READ;
                        end
                        KIND_RUN:
                        begin
                            w_next   = (XW+1)'(wc);
                            h_next   = (YW+1)'(hc);
                            x_next   = '0;
                            y_next   = '0;
                            lab_next = FIRST_LABEL;
                            too_next = 1'b0;
                            top_next = '0;
                            limit_next = lim_in;
                            if ({1'b0, {(PB-1){1'b1}}} > lim_in)
                            begin
                                maximum_next = {lim_in, 1'b0};
                            end
                            else
                            begin
                                maximum_next = {1'b0, {PB{1'b1}}};
                            end
                            if (wc == 11'd0 || hc == 11'd0)
                            begin
                                if (lim_in == '0)
                                begin
                                    maximum_next = '0;
                                end
                                state_next = S_DONE;
                            end
                            else if (lim_in == '0)
                            begin
                                maximum_next = '0;
                                state_next   = S_MAX_RD;
                            end
                            else
                            begin
                                state_next = S_CLS_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = ANS_READ;
                out_label_next = inside_reg ? lab_rdata : DIM_MARK;
                out_count_next = 8'd0;
                out_too_next   = 1'b0;
                state_next     = S_IDLE;
            end
            S_MAX_RD:
            begin
                state_next = S_MAX_CHK;
            end
            S_MAX_CHK:
            begin
                maximum_next = mx;
                if (scan_last)
                begin
                    limit_next = mx[PB:1];
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_CLS_RD;
                end
                else
                begin
                    x_next     = y_last ? x_reg + XW'(1) : x_reg;
                    y_next     = y_last ? '0 : y_reg + YW'(1);
                    state_next = S_MAX_RD;
                end
            end
            S_CLS_RD:
            begin
                state_next = S_CLS_WR;
            end
            S_CLS_WR:
            begin
                lab_we = 1'b1;
                if ({1'b0, pix_rdata} == maximum_reg)
                begin
                    lab_wdata = SEED_MARK;
                end
                else if (pix_rdata > limit_reg)
                begin
                    lab_wdata = BRIGHT_MARK;
                end
                else
                begin
                    lab_wdata = DIM_MARK;
                end
                if (scan_last)
                begin
                    x_next     = '0;
                    y_next     = '0;
                    state_next = S_SEED_RD;
                end
                else
                begin
                    x_next     = y_last ? x_reg + XW'(1) : x_reg;
                    y_next     = y_last ? '0 : y_reg + YW'(1);
                    state_next = S_CLS_RD;
                end
            end
            S_SEED_RD:
            begin
                state_next = S_SEED_CHK;
            end
            S_SEED_CHK:
            begin
                if (lab_rdata == SEED_MARK)
                begin
                    lab_we     = 1'b1;
                    stk_we     = 1'b1;
                    stk_addr   = '0;
                    stk_wdata  = {y_reg, x_reg};
                    top_next   = (AW+1)'(1);
                    state_next = S_POP;
                end
                else if (scan_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    x_next     = y_last ? x_reg + XW'(1) : x_reg;
                    y_next     = y_last ? '0 : y_reg + YW'(1);
                    state_next = S_SEED_RD;
                end
            end
            S_POP:
            begin
                if (top_reg == '0)
                begin
                    if (lab_reg == LAST_LABEL)
                    begin
                        too_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lab_next = lab_reg + 8'd1;
                        if (scan_last)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            x_next     = y_last ? x_reg + XW'(1) : x_reg;
                            y_next     = y_last ? '0 : y_reg + YW'(1);
                            state_next = S_SEED_RD;
                        end
                    end
                end
                else
                begin
                    top_next   = top_reg - (AW+1)'(1);
                    stk_addr   = AW'(top_reg - (AW+1)'(1));
                    state_next = S_POP_DATA;
                end
            end
            S_POP_DATA:
            begin
                p_next     = stk_rdata;
                k_next     = 2'd0;
                state_next = S_NB_SEL;
            end
            S_NB_SEL:
            begin
                lab_addr = {nb_y, nb_x};
                if (nb_ok)
                begin
                    state_next = S_NB_CHK;
                end
                else if (k_reg == 2'd3)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            S_NB_CHK:
            begin
                lab_addr = {nb_y, nb_x};
                if (lab_rdata == BRIGHT_MARK || lab_rdata == SEED_MARK)
                begin
                    lab_we   = 1'b1;
                    stk_we   = 1'b1;
                    top_next = top_reg + (AW+1)'(1);
                end
                if (k_reg == 2'd3)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_NB_SEL;
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = ANS_RUN;
                out_label_next = DIM_MARK;
                out_count_next = too_reg ? (LAST_LABEL - FIRST_LABEL + 8'd1)
                                         : (lab_reg - FIRST_LABEL);
                out_too_next   = too_reg;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            top_reg        <= '0;
            lab_reg        <= FIRST_LABEL;
            too_reg        <= 1'b0;
            maximum_reg    <= '0;
            width_cfg_reg  <= 7'd64;
            height_cfg_reg <= 7'd64;
            limit_cfg_reg  <= 16'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            top_reg       <= top_next;
            lab_reg       <= lab_next;
            too_reg       <= too_next;
            maximum_reg   <= maximum_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_cfg_reg  <= cfg_data[6:0];
                    REG_HEIGHT: height_cfg_reg <= cfg_data[6:0];
                    REG_LIMIT:  limit_cfg_reg  <= cfg_data;
                    default:    limit_cfg_reg  <= limit_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_reg         <= w_next;
        h_reg         <= h_next;
        limit_reg     <= limit_next;
        p_reg         <= p_next;
        k_reg         <= k_next;
        inside_reg    <= inside_next;
        out_kind_reg  <= out_kind_next;
        out_label_reg <= out_label_next;
        out_count_reg <= out_count_next;
        out_too_reg   <= out_too_next;
    end

    `BRL_ASSERT_IMPLIES(a_idle_stack_empty, clk, rst_n, state_reg == S_IDLE, top_reg == '0)
    `BRL_ASSERT_IMPLIES(a_label_range, clk, rst_n, 1'b1, lab_reg >= FIRST_LABEL && lab_reg <= LAST_LABEL)
    `BRL_ASSERT_NEXT(a_push_grows, clk, rst_n, state_reg == S_NB_CHK && stk_we, top_reg == $past(top_reg) + (AW+1)'(1))
    `BRL_ASSERT_IMPLIES(a_busy_no_accept, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// Bright region labeler testbench
// Loads images of many sizes, runs labeling and reads labels back over the
// valid/ready channels. A scoreboard class predicts each answer and checks
// every answer transaction field by field, in order.
// ----------------------------------------------------------------------------
class region_scoreboard;
    typedef struct {
        logic       answer_kind;
        logic [7:0] pixel_label;
        logic [7:0] component_count;
        logic       too_many;
    } answer_t;

    bit [15:0] pixels [4096];
    bit [7:0]  labels [4096];
    bit        pixel_loaded [4096];
    bit        label_known [4096];
    int        width_reg = 64;
    int        height_reg = 64;
    int        limit_reg = 0;
    int        last_w = 0;
    int        last_h = 0;
    answer_t   pending [$];
    int        errors = 0;
    int        runs = 0;
    int        overflows = 0;
    int        reads = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] data);
        if (idx == brl_pkg::REG_WIDTH)
            width_reg = int'(data[6:0]);
        else if (idx == brl_pkg::REG_HEIGHT)
            height_reg = int'(data[6:0]);
        else if (idx == brl_pkg::REG_LIMIT)
            limit_reg = int'(data);
    endfunction

    function void label_image(output int count, output bit too);
        int w, h, limit, peak, lab, sp, n, p, x, y, k;
        int stack [4096];
        int nb [4];
        w = (width_reg > 64) ? 64 : width_reg;
        h = (height_reg > 64) ? 64 : height_reg;
        last_w = w;
        last_h = h;
        limit = limit_reg;
        peak = 65535;
        if (32767 > limit)
            peak = 2 * limit;
        if (limit == 0)
        begin
            peak = 0;
            for (x = 0; x < w; x++)
                for (y = 0; y < h; y++)
                    if (int'(pixels[y * 64 + x]) > peak)
                        peak = int'(pixels[y * 64 + x]);
            limit = peak / 2;
        end
        for (x = 0; x < w; x++)
            for (y = 0; y < h; y++)
            begin
                p = y * 64 + x;
                labels[p] = (int'(pixels[p]) == peak) ? brl_pkg::SEED_MARK :
                            (int'(pixels[p]) > limit) ? brl_pkg::BRIGHT_MARK
                                                      : brl_pkg::DIM_MARK;
                label_known[p] = 1;
            end
        too = 0;
        lab = int'(brl_pkg::FIRST_LABEL);
        for (x = 0; x < w && !too; x++)
            for (y = 0; y < h && !too; y++)
                if (labels[y * 64 + x] == brl_pkg::SEED_MARK)
                begin
                    labels[y * 64 + x] = 8'(lab);
                    sp = 0;
                    stack[sp++] = y * 64 + x;
                    while (sp > 0)
                    begin
                        p = stack[--sp];
                        n = 0;
                        if (p % 64 > 0) nb[n++] = p - 1;
                        if (p / 64 > 0) nb[n++] = p - 64;
                        if (p % 64 + 1 < w) nb[n++] = p + 1;
                        if (p / 64 + 1 < h) nb[n++] = p + 64;
                        for (k = 0; k < n; k++)
                            if (labels[nb[k]] == brl_pkg::BRIGHT_MARK ||
                                labels[nb[k]] == brl_pkg::SEED_MARK)
                            begin
                                labels[nb[k]] = 8'(lab);
                                stack[sp++] = nb[k];
                            end
                    end
                    if (lab == int'(brl_pkg::LAST_LABEL))
                        too = 1;
                    else
                        lab++;
                end
        count = too ? 253 : lab - int'(brl_pkg::FIRST_LABEL);
    endfunction

    function void note_command(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                               logic [15:0] value);
        answer_t a;
        int count;
        bit too;
        if (kind == brl_pkg::KIND_LOAD)
        begin
            pixels[row * 64 + col] = value;
            pixel_loaded[row * 64 + col] = 1;
        end
        else if (kind == brl_pkg::KIND_RUN)
        begin
            label_image(count, too);
            a = '{brl_pkg::ANS_RUN, 8'd0, count[7:0], too};
            pending.insert(pending.size(), a);
            runs++;
            overflows += too;
        end
        else if (kind == brl_pkg::KIND_READ)
        begin
            a = '{brl_pkg::ANS_READ, labels[row * 64 + col], 8'd0, 1'b0};
            pending.insert(pending.size(), a);
            reads++;
        end
    endfunction

    function void check_answer(logic ak, logic [7:0] lbl, logic [7:0] cnt, logic too);
        answer_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected answer kind=%0d label=%0d count=%0d too_many=%0d",
                     $time, ak, lbl, cnt, too);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (ak !== e.answer_kind || lbl !== e.pixel_label ||
            cnt !== e.component_count || too !== e.too_many)
        begin
            $display("%0t: mismatch expected kind=%0d label=%0d count=%0d too_many=%0d",
                     $time, e.answer_kind, e.pixel_label, e.component_count, e.too_many);
            $display("%0t:          actual   kind=%0d label=%0d count=%0d too_many=%0d",
                     $time, ak, lbl, cnt, too);
            errors++;
        end
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_off = 0;
    int          sent = 0;
    region_scoreboard board = new();

    brl_in_if  cmd_ch ();
    brl_out_if ans_ch ();

    bright_region_labeler u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (cmd_ch.sink),
        .out_ch    (ans_ch.source)
    );

    always #10 clk = ~clk;

    initial
    begin
        cmd_ch.valid = 0;
        cmd_ch.kind = '0;
        cmd_ch.col = '0;
        cmd_ch.row = '0;
        cmd_ch.pixel_value = '0;
        ans_ch.ready = 0;
    end

    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            ans_ch.ready <= 1'b0;
        end
        else
            ans_ch.ready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && ans_ch.valid && ans_ch.ready)
            board.check_answer(ans_ch.answer_kind, ans_ch.pixel_label,
                               ans_ch.component_count, ans_ch.too_many);
    end

    task automatic send(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                        logic [15:0] value);
        while ($urandom_range(99) < send_idle)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.kind <= kind;
        cmd_ch.col <= col;
        cmd_ch.row <= row;
        cmd_ch.pixel_value <= value;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        board.note_command(kind, col, row, value);
        sent++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic setup(int w, int h, int limit);
        drain();
        write_reg(brl_pkg::REG_WIDTH, 16'(w));
        write_reg(brl_pkg::REG_HEIGHT, 16'(h));
        write_reg(brl_pkg::REG_LIMIT, 16'(limit));
    endtask

    // Reads inside the window of the last run, where every label is defined.
    task automatic read_some(int n);
        int c, r;
        if (board.last_w == 0 || board.last_h == 0)
            return;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(board.last_w - 1);
            r = $urandom_range(board.last_h - 1);
            send(brl_pkg::KIND_READ, 6'(c), 6'(r), 16'($urandom));
        end
    endtask

    // One image: registers, a full load of the window with some stray loads and
    // ignored commands, a run, then reads of labels.
    task automatic image_session(int w, int h, int limit, int nreads);
        int peak, v;
        peak = $urandom_range(65535, 1);
        setup(w, h, limit);
        for (int x = 0; x < w && x < 64; x++)
            for (int y = 0; y < h && y < 64; y++)
            begin
                case ($urandom_range(9))
                    0, 1, 2: v = 0;
                    3, 4, 5: v = peak;
                    6, 7, 8: v = $urandom_range(peak, peak / 2);
                    default: v = $urandom_range(65535);
                endcase
                send(brl_pkg::KIND_LOAD, 6'(x), 6'(y), 16'(v));
                if ($urandom_range(19) == 0)
                    send(brl_pkg::KIND_LOAD, 6'($urandom), 6'($urandom), 16'($urandom));
                if ($urandom_range(29) == 0)
                    send(KIND_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom));
            end
        send(brl_pkg::KIND_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
        read_some(nreads);
    endtask

    task automatic random_phase(int items);
        int start, w, h, limit;
        start = sent;
        while (sent < start + items)
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(127, 1) % 17 + 1
                                         : $urandom_range(6, 1);
            h = $urandom_range(6, 1);
            case ($urandom_range(3))
                0, 1: limit = 0;
                2: limit = $urandom_range(40000);
                default: limit = $urandom_range(65535);
            endcase
            image_session(w, h, limit, $urandom_range(20, 4));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of values, every kind, ignored kind.
        image_session(4, 3, 0, 0);
        send(brl_pkg::KIND_LOAD, 6'd0, 6'd0, 16'hFFFF);
        send(brl_pkg::KIND_LOAD, 6'd1, 6'd0, 16'h0000);
        send(brl_pkg::KIND_LOAD, 6'd63, 6'd63, 16'hAAAA);
        send(KIND_UNUSED, 6'h3F, 6'h3F, 16'h5555);
        send(brl_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0);
        for (int i = 0; i < 4; i++)
            send(brl_pkg::KIND_READ, 6'(i), 6'(i % 3), 16'd0);
        setup(0, 5, 0);
        send(brl_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0);
        image_session(127, 1, 65535, 6);
        image_session(1, 127, 32767, 6);
        image_session(3, 3, 1, 6);

        send_idle = 34;
        recv_idle = 81;
        random_phase(70);
        drain();
        hold_off = 400;
        read_some(20);

        send_idle = 81;
        recv_idle = 34;
        random_phase(70);

        send_idle = 0;
        recv_idle = 0;
        random_phase(70);

        // Checkerboard of isolated seeds over the full width to exceed the
        // label range.
        setup(64, 8, 100);
        for (int x = 0; x < 64; x++)
            for (int y = 0; y < 8; y++)
                send(brl_pkg::KIND_LOAD, 6'(x), 6'(y),
                     ((x + y) % 2 == 0) ? 16'd200 : 16'd0);
        send(brl_pkg::KIND_RUN, 6'd0, 6'd0, 16'd0);
        send(brl_pkg::KIND_READ, 6'd30, 6'd6, 16'd0);
        send(brl_pkg::KIND_READ, 6'd63, 6'd7, 16'd0);
        send(brl_pkg::KIND_READ, 6'd0, 6'd0, 16'd0);
        drain();

        $display("Covered %0d transactions: %0d runs (%0d overflowed) and %0d label reads.",
                 sent, board.runs, board.overflows, board.reads);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Timeout with %0d answers outstanding.", board.pending.size());
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/brl_pkg.sv
design/brl_if.sv
design/brl_ram.sv
design/brl_ctrl.sv
design/bright_region_labeler.sv
verif/tb.sv
